### hdl/rppc_pkg.sv
package rppc_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SPAN     = 2'd0;
  localparam logic [1:0] REG_GAIN_I   = 2'd1;
  localparam logic [1:0] REG_GAIN_D   = 2'd2;
  localparam logic [1:0] REG_SEG_CNT  = 2'd3;

  localparam int CFG_IDX_W = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  entry_index;
    logic [11:0] segment_duration;
    logic [11:0] segment_temp;
    logic [11:0] measured_temp;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  control_value;
    logic [11:0] setpoint;
    logic [5:0]  segment_number;
    logic [15:0] run_second;
    logic        running;
    logic        finished;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;   // capture input item
    logic do_load;     // write profile slot
    logic do_start;    // reset run state
    logic do_tick;     // bump second counter
    logic do_advance;  // segment advance check (uses read data)
    logic rd_next;     // issue profile read for next segment
    logic interp_go;   // start interpolation divide
    logic ctrl_go;     // control law first step
    logic pid_go;      // start PID divide
    logic pid_fin;     // commit PID result
    logic do_end;      // end run
    logic do_abort;
    logic out_load;    // build result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       run_active;
    logic       adv;        // advance taken
    logic       exhausted;  // profile over
    logic       need_div;   // interpolation divide required
    logic       pid_path;   // PID divide required
    logic       div_busy;
  } stat_t;

endpackage

### hdl/rppc_div.sv
module rppc_div #(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,   // magnitude
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  // One quotient bit per cycle, restoring
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule

### hdl/rppc_ctrl.sv
module rppc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rppc_pkg::stat_t st,
  output rppc_pkg::cmd_t  cmd
);
  import rppc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_ADV   = 11'b00000001000,
    S_IDIV  = 11'b00000010000,
    S_CTRL  = 11'b00000100000,
    S_PDIV  = 11'b00001000000,
    S_PFIN  = 11'b00010000000,
    S_OUT   = 11'b00100000000,
    S_WAIT  = 11'b01000000000,
    S_ISET  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        case (st.kind)
          KIND_LOAD: begin
            cmd.do_load = 1'b1;
            state_nxt   = S_OUT;
          end
          KIND_START: begin
            cmd.do_start = 1'b1;
            cmd.rd_next  = 1'b1;
            state_nxt    = S_RD;
          end
          KIND_TICK: begin
            if (st.run_active) begin
              cmd.do_tick = 1'b1;
              cmd.rd_next = 1'b1;
              state_nxt   = S_RD;
            end else begin
              state_nxt = S_OUT;
            end
          end
          default: begin
            cmd.do_abort = 1'b1;
            state_nxt    = S_OUT;
          end
        endcase
      end
      // read data lands this cycle
      S_RD: state_nxt = S_ADV;
      S_ADV: begin
        cmd.do_advance = 1'b1;
        state_nxt      = S_ISET;
      end
      S_ISET: begin
        if (st.exhausted) begin
          cmd.do_end = 1'b1;
          state_nxt  = S_OUT;
        end else if (st.need_div) begin
          cmd.interp_go = 1'b1;
          state_nxt     = S_IDIV;
        end else begin
          state_nxt = S_CTRL;
        end
      end
      S_IDIV: if (!st.div_busy) state_nxt = S_CTRL;
      S_CTRL: begin
        cmd.ctrl_go = 1'b1;
        state_nxt   = st.pid_path ? S_PDIV : S_OUT;
        cmd.pid_go  = st.pid_path;
      end
      S_PDIV: if (!st.div_busy) state_nxt = S_PFIN;
      S_PFIN: begin
        cmd.pid_fin = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // A result is only built when the output register is free or draining
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrites pending item");
  // Divider is never started while busy
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.interp_go || cmd.pid_go) |-> !st.div_busy)
    else $error("divider restarted while busy");
  // After accepting an item, input stays blocked next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");
`endif
endmodule

### hdl/rppc_dp.sv
module rppc_dp #(
  parameter int MAX_SEGMENTS = 32,
  parameter int MAX_POWER    = 1023,
  parameter int MIN_TEMP     = 200
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rppc_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic [rppc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wd,
  input  rppc_pkg::cmd_t       cmd,
  output rppc_pkg::stat_t      st,
  output rppc_pkg::out_item_t  out_data
);
  import rppc_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int PW = $clog2(MAX_POWER + 1);
  localparam int SW = 9; // segment index incl. sign, up to 255
  localparam logic [11:0] MIN_T = 12'(MIN_TEMP);
  localparam int NW = 48;

  // Configuration
  logic [11:0] span_r, gi_r, gd_r;
  logic [5:0]  segcnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= 12'd100;
      gi_r     <= '0;
      gd_r     <= '0;
      segcnt_r <= '0;
    end else if (cfg_we && cfg_idx[CFG_IDX_W-1:2] == '0) begin
      case (cfg_idx[1:0])
        REG_SPAN:   span_r   <= cfg_wd[11:0];
        REG_GAIN_I: gi_r     <= cfg_wd[11:0];
        REG_GAIN_D: gd_r     <= cfg_wd[11:0];
        REG_SEG_CNT: segcnt_r <= cfg_wd[5:0];
        default: ;
      endcase
    end
  end

  // Item capture
  in_item_t it_r;
  always_ff @(posedge clk) if (cmd.load_item) it_r <= in_data;

  // Profile memory
  logic [23:0] mem [MAX_SEGMENTS];
  logic [23:0] rd_r;
  logic [SW-1:0] seg_r;
  logic [SW-1:0] seg_inc;
  assign seg_inc = seg_r + SW'(1);
  logic [AW-1:0] rd_addr;
  assign rd_addr = (cmd.do_start) ? '0 : seg_inc[AW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.do_load && (9'(it_r.entry_index) < 9'(MAX_SEGMENTS)))
      mem[AW'(it_r.entry_index)] <= {it_r.segment_duration, it_r.segment_temp};
    if (cmd.rd_next) rd_r <= mem[rd_addr];
  end

  // Run state
  logic        act_r, fin_r, heat_r, reach_r;
  logic [15:0] sec_r, sst_r, send_r;
  logic [11:0] stt_r, ft_r, slen_r, sp_r;
  logic [31:0] integ_r;
  logic [12:0] perr_r;
  logic [PW-1:0] pw_r;
  logic        adv_r, exh_r, need_r, neg_r;
  logic signed [47:0] t_r;
  logic        sp_from_div_r;

  logic [11:0] meas;
  assign meas = it_r.measured_temp;

  // Advance decision
  logic [8:0] cnt_eff;
  assign cnt_eff = ({3'b0, segcnt_r} > 9'(MAX_SEGMENTS)) ? 9'(MAX_SEGMENTS)
                                                          : {3'b0, segcnt_r};
  logic reach_now, take;
  assign reach_now = reach_r ? 1'b1 : (heat_r ? (meas >= ft_r) : (meas <= ft_r));
  assign take = reach_now && (sec_r >= send_r);

  // End second of a newly taken segment; wraps like the second counter
  logic [15:0] new_send;
  logic        new_hold;
  assign new_send = sec_r + {4'b0, rd_r[23:12]};
  assign new_hold = (sec_r >= new_send) || (rd_r[23:12] == '0);

  // Interpolation: (ft-st)*el, sign-magnitude divide by slen
  logic signed [12:0] diff_w;
  logic [15:0] el_w;
  logic [12:0] dmag;
  logic [28:0] prod_w;
  assign diff_w = $signed({1'b0, ft_r}) - $signed({1'b0, stt_r});
  assign el_w   = sec_r - sst_r;
  assign dmag   = diff_w[12] ? 13'(-diff_w) : diff_w;
  assign prod_w = dmag * el_w;

  // Shared divider signals
  logic          dv_start;
  logic [NW-1:0] dv_num, dv_q;
  logic [15:0]   dv_den;
  logic          dv_busy;

  // interpolation result
  logic signed [14:0] iv;
  assign iv = neg_r ? ($signed({3'b0, stt_r}) - $signed({1'b0, dv_q[13:0]}))
                    : ($signed({3'b0, stt_r}) + $signed({1'b0, dv_q[13:0]}));
  logic [11:0] iv_sat;
  assign iv_sat = (iv < 0) ? 12'd0 : ((iv > 15'sd4095) ? 12'd4095 : iv[11:0]);

  // Setpoint for the control step: divide result while still pending
  logic [11:0] sp_eff;
  assign sp_eff = sp_from_div_r ? iv_sat : sp_r;

  // PID terms
  logic signed [13:0] er_w;
  assign er_w = $signed({2'b0, sp_eff}) - $signed({2'b0, meas});
  logic [11:0] er_u;
  assign er_u = er_w[11:0];
  logic signed [47:0] t_w;
  logic [43:0] ig_prod;
  logic signed [26:0] d_prod;
  logic [27:0] p_prod;
  assign p_prod  = 28'(er_u) * 28'(MAX_POWER);
  assign ig_prod = integ_r * gi_r;
  assign d_prod  = ($signed({2'b0, er_u}) - $signed(perr_r)) * $signed({1'b0, gd_r});
  assign t_w = 48'(p_prod) + 48'(ig_prod) + 48'(d_prod);

  // Shared divider
  assign dv_start = cmd.interp_go | cmd.pid_go;
  assign dv_num = cmd.pid_go ? NW'(t_w[47] ? -t_w : t_w) : NW'(prod_w);
  assign dv_den = cmd.pid_go ? {4'b0, span_r} : {4'b0, slen_r};
  rppc_div #(.NW(NW), .DW(16)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quo(dv_q)
  );

  logic [32:0] isum;
  assign isum = {1'b0, integ_r} + {21'b0, er_u};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0; fin_r <= 1'b0; sec_r <= '0; seg_r <= '1;
      stt_r   <= '0;   ft_r  <= MIN_T; sst_r <= '0; send_r <= '0;
      slen_r  <= '0;   heat_r <= 1'b1; reach_r <= 1'b1; integ_r <= '0;
      perr_r  <= '0;   pw_r <= '0; sp_r <= '0; sp_from_div_r <= 1'b0;
      exh_r <= 1'b0; need_r <= 1'b0; neg_r <= 1'b0; adv_r <= 1'b0;
    end else begin
      if (cmd.load_item) fin_r <= 1'b0;
      if (cmd.do_start) begin
        sec_r <= '0; send_r <= '0; seg_r <= '1; heat_r <= 1'b1;
        ft_r <= MIN_T; perr_r <= '0; integ_r <= '0; reach_r <= 1'b1; act_r <= 1'b1;
      end
      if (cmd.do_tick) sec_r <= sec_r + 16'd1;
      if (cmd.do_abort && act_r) begin
        act_r <= 1'b0; pw_r <= '0; sp_r <= '0; fin_r <= 1'b1;
      end
      // segment advance
      if (cmd.do_advance) begin
        adv_r <= take;
        sp_from_div_r <= 1'b0;
        reach_r <= reach_now;
        exh_r <= 1'b0;
        if (take) begin
          seg_r <= seg_inc;
          if ($signed(seg_inc) >= $signed({1'b0, cnt_eff[7:0]})) begin
            exh_r <= 1'b1;
          end else begin
            stt_r  <= ft_r;
            ft_r   <= rd_r[11:0];
            sst_r  <= sec_r;
            slen_r <= rd_r[23:12];
            send_r <= new_send;
            heat_r <= rd_r[11:0] > meas;
            reach_r <= 1'b0;
            // no time elapsed yet: the ramp starts at the old target, or at the new one if it holds
            need_r <= 1'b0;
            sp_r   <= new_hold ? rd_r[11:0] : ft_r;
          end
        end else begin
          need_r <= !((sec_r >= send_r) || (slen_r == '0));
          if ((sec_r >= send_r) || (slen_r == '0)) sp_r <= ft_r;
        end
      end
      if (cmd.interp_go) begin
        neg_r <= diff_w[12];
        sp_from_div_r <= 1'b1;
      end
      if (cmd.do_end) begin
        act_r <= 1'b0; pw_r <= '0; sp_r <= '0; fin_r <= 1'b1;
      end
      // control law
      if (cmd.ctrl_go) begin
        if (sp_from_div_r) begin
          sp_r <= iv_sat;
          sp_from_div_r <= 1'b0;
        end
        if (er_w < 0) begin
          perr_r <= '0; pw_r <= '0;
        end else if (er_w >= $signed({2'b0, span_r})) begin
          integ_r <= '0;
          perr_r  <= er_w[12:0];
          if (er_w > 0) pw_r <= PW'(MAX_POWER);
        end else begin
          t_r <= t_w;
        end
      end
      if (cmd.pid_fin) begin
        if (t_r[47]) pw_r <= '0;
        else if (dv_q > NW'(MAX_POWER)) pw_r <= PW'(MAX_POWER);
        else pw_r <= dv_q[PW-1:0];
        integ_r <= isum[32] ? 32'hFFFF_FFFF : isum[31:0];
        perr_r  <= er_w[12:0];
      end
    end
  end

  assign st.kind       = it_r.kind;
  assign st.run_active = act_r;
  assign st.adv        = adv_r;
  assign st.exhausted  = exh_r;
  assign st.need_div   = need_r;
  assign st.pid_path   = (er_w >= 0) && (er_w < $signed({2'b0, span_r}));
  assign st.div_busy   = dv_busy;

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.control_value  <= act_r ? 10'(pw_r) : '0;
      out_data.setpoint       <= act_r ? sp_r : '0;
      out_data.segment_number <= seg_r[SW-1] ? 6'd0 : seg_r[5:0];
      out_data.run_second     <= sec_r;
      out_data.running        <= act_r;
      out_data.finished       <= fin_r;
    end
  end
endmodule

### hdl/reflow_profile_pid_controller.sv
// Flow: each accepted item is decoded; load, abort and idle tick go straight to the result,
// while start and tick read the profile, check the segment advance and may run up to two
// 48-bit one-bit-per-cycle divides (interpolation, then the PID term with its commit).
// Throughput: one item at a time; the input is free in the cycle after the result is built,
// and building waits while the previous result is still held by the receiver.
// Reset: synchronous, active low; run state and configuration registers go to their reset
// values, the profile memory keeps its contents and is undefined until loaded.
module reflow_profile_pid_controller #(
  parameter int MAX_SEGMENTS = 32,
  parameter int MAX_POWER    = 1023,
  parameter int MIN_TEMP     = 200
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rppc_pkg::in_item_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rppc_pkg::out_item_t      out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [rppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]              cfg_data
);
  import rppc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  rppc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
  );

  rppc_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_POWER(MAX_POWER), .MIN_TEMP(MIN_TEMP)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wd(cfg_data),
    .cmd(cmd), .st(st), .out_data(out_data)
  );
endmodule

### sim/tb_reflow_profile_pid_controller.sv
`timescale 1ns / 100ps

module tb_reflow_profile_pid_controller;
  import rppc_pkg::*;

  localparam int SEG_SLOTS = 32;
  localparam int POWER_MAX = 1023;
  localparam int TEMP_MIN  = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  reflow_profile_pid_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // configuration copy
  logic [11:0] span_r, gain_i_r, gain_d_r;
  logic [5:0]  seg_cnt_r;

  // controller state copy
  logic [11:0] prof_dur [SEG_SLOTS];
  logic [11:0] prof_temp [SEG_SLOTS];
  bit          run_on;
  logic [15:0] cur_sec, seg_start, seg_end;
  int          cur_seg;
  logic [11:0] start_t, final_t, seg_len, setpoint_now;
  bit          heat_up, reached;
  logic [31:0] integ;
  int          prev_err;
  logic [9:0]  power;

  out_item_t   expected_q[$];
  int          mismatches;
  int          items_sent;
  int          results_seen;
  int          runs_ended;
  int          hold_left;
  bit          send_gaps;
  bit          recv_gaps;

  // run restart
  function automatic void begin_run();
    cur_sec  = '0;
    seg_end  = '0;
    cur_seg  = -1;
    heat_up  = 1'b1;
    final_t  = 12'(TEMP_MIN);
    prev_err = 0;
    integ    = '0;
    reached  = 1'b1;
    run_on   = 1'b1;
  endfunction

  // segment progression and setpoint; returns 0 once the profile is over
  function automatic bit track_profile(logic [11:0] meas);
    int     cnt;
    longint df, el, v;
    logic [15:0] gone;
    cnt = (seg_cnt_r > SEG_SLOTS) ? SEG_SLOTS : seg_cnt_r;
    if (!reached)
      reached = heat_up ? (meas >= final_t) : (meas <= final_t);
    if (reached && cur_sec >= seg_end) begin
      cur_seg++;
      if (cur_seg >= cnt)
        return 1'b0;
      start_t   = final_t;
      final_t   = prof_temp[cur_seg];
      seg_start = cur_sec;
      seg_len   = prof_dur[cur_seg];
      seg_end   = cur_sec + 16'(seg_len);
      heat_up   = final_t > meas;
      reached   = 1'b0;
    end
    if (cur_sec >= seg_end || seg_len == 0) begin
      setpoint_now = final_t;
    end else begin
      df   = longint'(final_t) - longint'(start_t);
      gone = cur_sec - seg_start;
      el   = gone;
      v    = longint'(start_t) + (df * el) / longint'(seg_len);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      setpoint_now = 12'(v);
    end
    return 1'b1;
  endfunction

  // span-normalised PID law
  function automatic void oven_power(logic [11:0] meas);
    int     er;
    longint t, sum;
    er = int'(setpoint_now) - int'(meas);
    if (er < 0) begin
      prev_err = 0;
      power    = '0;
      return;
    end
    if (er >= int'(span_r)) begin
      integ    = '0;
      prev_err = er;
      if (er > 0) power = 10'(POWER_MAX);
      return;
    end
    t = longint'(er) * POWER_MAX;
    t += longint'(integ) * longint'(gain_i_r);
    t += (longint'(er) - longint'(prev_err)) * longint'(gain_d_r);
    t = t / longint'(span_r);
    if (t < 0) power = '0;
    else if (t > POWER_MAX) power = 10'(POWER_MAX);
    else power = 10'(t);
    sum = longint'(integ) + longint'(er);
    integ = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
    prev_err = er;
  endfunction

  function automatic bit oven_second(logic [11:0] meas);
    if (!track_profile(meas)) begin
      run_on       = 1'b0;
      power        = '0;
      setpoint_now = '0;
      return 1'b1;
    end
    oven_power(meas);
    return 1'b0;
  endfunction

  // expected status for one item
  function automatic out_item_t oven_status(in_item_t it);
    out_item_t r;
    bit        fin;
    fin = 1'b0;
    case (kind_t'(it.kind))
      KIND_LOAD: begin
        prof_dur[it.entry_index]  = it.segment_duration;
        prof_temp[it.entry_index] = it.segment_temp;
      end
      KIND_START: begin
        begin_run();
        fin = oven_second(it.measured_temp);
      end
      KIND_TICK: begin
        if (run_on) begin
          cur_sec = cur_sec + 16'd1;
          fin = oven_second(it.measured_temp);
        end
      end
      default: begin
        if (run_on) begin
          run_on       = 1'b0;
          power        = '0;
          setpoint_now = '0;
          fin          = 1'b1;
        end
      end
    endcase
    r.control_value  = run_on ? power : '0;
    r.setpoint       = run_on ? setpoint_now : '0;
    r.segment_number = (cur_seg < 0) ? 6'd0 : 6'(cur_seg);
    r.run_second     = cur_sec;
    r.running        = run_on;
    r.finished       = fin;
    if (fin) runs_ended++;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one item on the input channel
  task automatic send_item(in_item_t it);
    int gap;
    gap = send_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(oven_status(it));
    items_sent++;
  endtask

  // wait for all results plus the block's worst latency
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IDX_W'(REG_SPAN):    span_r    = val[11:0];
      CFG_IDX_W'(REG_GAIN_I):  gain_i_r  = val[11:0];
      CFG_IDX_W'(REG_GAIN_D):  gain_d_r  = val[11:0];
      CFG_IDX_W'(REG_SEG_CNT): seg_cnt_r = val[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // set all registers; upper data bits carry noise
  task automatic configure(int sp, int gi, int gd, int cnt);
    drain();
    write_reg(CFG_IDX_W'(REG_SPAN),    {$urandom} << 12 | 32'(sp));
    write_reg(CFG_IDX_W'(REG_GAIN_I),  {$urandom} << 12 | 32'(gi));
    write_reg(CFG_IDX_W'(REG_GAIN_D),  {$urandom} << 12 | 32'(gd));
    write_reg(CFG_IDX_W'(REG_SEG_CNT), {$urandom} << 6  | 32'(cnt));
  endtask

  function automatic in_item_t make_item(kind_t k, int idx, int dur, int tmp, int meas);
    in_item_t it;
    it.kind             = k;
    it.entry_index      = 5'(idx);
    it.segment_duration = 12'(dur);
    it.segment_temp     = 12'(tmp);
    it.measured_temp    = 12'(meas);
    return it;
  endfunction

  // temperature near the current setpoint, sometimes anywhere
  function automatic int oven_temp();
    int m;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 4095);
    m = int'(setpoint_now) + $urandom_range(0, 80) - 40;
    if (m < 0) m = 0;
    if (m > 4095) m = 4095;
    return m;
  endfunction

  // profile loads fill every slot so no run reads an empty one
  task automatic test_profile_load();
    for (int i = 0; i < SEG_SLOTS; i++)
      send_item(make_item(KIND_LOAD, i, $urandom_range(0, 4), $urandom_range(0, 4095),
                          $urandom_range(0, 4095)));
  endtask

  // directed corners
  task automatic test_corners();
    configure(100, 0, 0, 0);
    send_item(make_item(KIND_TICK, 0, 0, 0, 100));     // tick while idle
    send_item(make_item(KIND_ABORT, 0, 0, 0, 0));      // abort while idle
    send_item(make_item(KIND_START, 0, 0, 0, 4095));   // empty profile ends at once
    configure(1, 4095, 4095, 3);
    send_item(make_item(KIND_LOAD, 0, 0, 4095, 0));
    send_item(make_item(KIND_LOAD, 1, 4095, 0, 4095));
    send_item(make_item(KIND_LOAD, 2, 2, 1000, 0));
    send_item(make_item(KIND_START, 0, 0, 0, 0));      // error beyond span
    send_item(make_item(KIND_TICK, 0, 0, 0, 4095));    // too hot
    send_item(make_item(KIND_TICK, 0, 0, 0, 4095));
    send_item(make_item(KIND_START, 0, 0, 0, 4095));   // restart while running
    send_item(make_item(KIND_LOAD, 31, 4095, 4095, 0)); // load during run
    send_item(make_item(KIND_ABORT, 0, 0, 0, 0));      // abort while running
    configure(4095, 4095, 4095, 2);
    send_item(make_item(KIND_LOAD, 0, 3, 600, 0));
    send_item(make_item(KIND_LOAD, 1, 0, 0, 0));
    send_item(make_item(KIND_START, 0, 0, 0, 200));    // zero error takes the PID path
    for (int i = 0; i < 6; i++)
      send_item(make_item(KIND_TICK, 0, 0, 0, 600 - i));
  endtask

  // random runs under one register setting
  task automatic test_random_runs(int sp, int gi, int gd, int cnt, int budget);
    int done, ticks;
    configure(sp, gi, gd, cnt);
    send_gaps = $urandom_range(0, 1);
    recv_gaps = $urandom_range(0, 1);
    done = 0;
    while (done < budget) begin
      // refresh a few slots, short durations mostly
      repeat ($urandom_range(0, 3)) begin
        send_item(make_item(KIND_LOAD, $urandom_range(0, 31),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, 5),
                  $urandom_range(0, 4095), $urandom_range(0, 4095)));
        done++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_item(make_item(kind_t'($urandom_range(2, 3)), $urandom_range(0, 31),
                  $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095)));
      end
      send_item(make_item(KIND_START, $urandom_range(0, 31), $urandom_range(0, 4095),
                $urandom_range(0, 4095), oven_temp()));
      done++;
      ticks = $urandom_range(5, 60);
      while (run_on && ticks > 0) begin
        send_item(make_item(KIND_TICK, $urandom_range(0, 31), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), oven_temp()));
        ticks--;
        done++;
        if ($urandom_range(0, 40) == 0) begin
          send_item(make_item(KIND_START, 0, 0, 0, oven_temp()));
          done++;
        end
      end
      if (run_on) begin
        send_item(make_item(KIND_ABORT, $urandom_range(0, 31), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095)));
        done++;
      end
    end
  endtask

  // output stalls stop the block and back up the input
  task automatic test_backpressure();
    configure(300, 2, 5, 6);
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      send_item(make_item(KIND_TICK, 0, 0, 0, oven_temp()));
    send_item(make_item(KIND_START, 0, 0, 0, oven_temp()));
    for (int i = 0; i < 12; i++)
      send_item(make_item(KIND_TICK, 0, 0, 0, oven_temp()));
  endtask

  // receiver side
  always @(posedge clk) begin : result_ready
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall = 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready && recv_gaps) begin
      stall = $urandom_range(0, 3);
      out_ready <= (stall == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("ERROR at %0t: result with nothing outstanding", $time);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.control_value != want.control_value)
          report("control_value", out_data.control_value, want.control_value);
        if (out_data.setpoint != want.setpoint)
          report("setpoint", out_data.setpoint, want.setpoint);
        if (out_data.segment_number != want.segment_number)
          report("segment_number", out_data.segment_number, want.segment_number);
        if (out_data.run_second != want.run_second)
          report("run_second", out_data.run_second, want.run_second);
        if (out_data.running != want.running)
          report("running", out_data.running, want.running);
        if (out_data.finished != want.finished)
          report("finished", out_data.finished, want.finished);
      end
    end
  end

  // watchdog
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    span_r = 12'd100; gain_i_r = '0; gain_d_r = '0; seg_cnt_r = '0;
    run_on = 1'b0; cur_sec = '0; cur_seg = -1; start_t = '0;
    final_t = 12'(TEMP_MIN); seg_start = '0; seg_end = '0; seg_len = '0;
    heat_up = 1'b1; reached = 1'b1; integ = '0; prev_err = 0; power = '0;
    setpoint_now = '0;
    mismatches = 0; items_sent = 0; results_seen = 0; runs_ended = 0;
    hold_left = 0; send_gaps = 1'b1; recv_gaps = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_profile_load();
    test_corners();
    // unused register index is ignored
    drain();
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
    test_backpressure();
    test_random_runs(100, 0, 0, 4, 250);
    test_random_runs(1, 4095, 4095, 32, 250);
    test_random_runs(4095, 0, 4095, 8, 250);
    test_random_runs(50, 7, 3, 63, 250);
    test_random_runs(4095, 4095, 0, 1, 200);
    test_random_runs(200, 20, 40, 0, 100);
    test_random_runs(30, 1, 100, 12, 250);
    drain();

    $display("Covered %0d items, %0d results, %0d completed or aborted runs,",
             items_sent, results_seen, runs_ended);
    $display("over several span, gain and segment-count settings with stalls.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### reflow_profile_pid_controller.f
hdl/rppc_pkg.sv
hdl/rppc_div.sv
hdl/rppc_ctrl.sv
hdl/rppc_dp.sv
hdl/reflow_profile_pid_controller.sv
sim/tb_reflow_profile_pid_controller.sv
